[hw/rtl/ctsg_pkg.sv]
package ctsg_pkg;

    localparam int BYTE_W = 8;

    // event kinds carried on s_tuser
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_PUT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TX_EMPTY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CTS_EDGE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 2'd3;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNEXPECTED = 2'd2;

    // handshake state codes as seen on the result
    localparam int LINK_W = 3;
    localparam logic [LINK_W-1:0] LS_READY      = 3'd0;
    localparam logic [LINK_W-1:0] LS_WAITING    = 3'd1;
    localparam logic [LINK_W-1:0] LS_SLOW_BOX   = 3'd2;
    localparam logic [LINK_W-1:0] LS_BOTH_SLOW  = 3'd3;
    localparam logic [LINK_W-1:0] LS_PROCESSING = 3'd4;

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_BYTE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_LEN = 1'b1;
    localparam logic [BYTE_W-1:0] REQ_BYTE_RST  = 8'h85;
    localparam logic [BYTE_W-1:0] REPLY_LEN_RST = 8'd10;

    // result tdata layout
    localparam int OUT_W      = 16;
    localparam int OUT_TXV    = 0;
    localparam int OUT_BYTE_L = 1;
    localparam int OUT_STAT_L = OUT_BYTE_L + BYTE_W;
    localparam int OUT_LINK_L = OUT_STAT_L + STATUS_W;
    localparam int OUT_BUSY   = OUT_LINK_L + LINK_W;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } q_ctrl_t;

    typedef struct packed {
        logic              full;
        logic              avail;
        logic [BYTE_W-1:0] head;
    } q_stat_t;

    typedef struct packed {
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic [STATUS_W-1:0] status;
        logic [LINK_W-1:0]   link_state;
        logic                sensor_busy;
    } result_t;

endpackage

[hw/rtl/ctsg_ram.sv]
module ctsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ctsg_queue.sv]
module ctsg_queue #(
    parameter int DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctsg_pkg::q_ctrl_t ctrl,
    output ctsg_pkg::q_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          byp_valid_reg, byp_valid_next;
    logic [ctsg_pkg::BYTE_W-1:0] byp_data_reg;
    logic [ctsg_pkg::BYTE_W-1:0] rdata;
    logic [ctsg_pkg::BYTE_W-1:0] stored_head;
    logic full, empty, push_ok;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] res;
        if (ptr == AW'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = ctrl.push && !full;

    // memory read is registered; a write into the address being fetched is forwarded
    assign stored_head = byp_valid_reg ? byp_data_reg : rdata;

    assign stat.full  = full;
    assign stat.avail = !empty || push_ok;
    assign stat.head  = empty ? ctrl.data : stored_head;

    assign head_next      = ctrl.pop ? ptr_inc(head_reg) : head_reg;
    assign tail_next      = push_ok ? ptr_inc(tail_reg) : tail_reg;
    assign count_next     = count_reg + CW'(push_ok) - CW'(ctrl.pop);
    assign byp_valid_next = push_ok && (tail_reg == head_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ctrl.data;
    end

    ctsg_ram #(
        .WIDTH (ctsg_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (tail_reg),
        .wdata (ctrl.data),
        .raddr (head_next),
        .rdata (rdata)
    );

endmodule

[hw/rtl/ctsg_link.sv]
module ctsg_link (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ctsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctsg_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                              step,
    input  logic [ctsg_pkg::CMD_W-1:0]        cmd,
    input  ctsg_pkg::q_stat_t                 qstat,
    output logic                              pop,
    output ctsg_pkg::result_t                 res
);

    typedef enum logic [ctsg_pkg::LINK_W-1:0] {
        ST_READY      = ctsg_pkg::LS_READY,
        ST_WAITING    = ctsg_pkg::LS_WAITING,
        ST_SLOW_BOX   = ctsg_pkg::LS_SLOW_BOX,
        ST_BOTH_SLOW  = ctsg_pkg::LS_BOTH_SLOW,
        ST_PROCESSING = ctsg_pkg::LS_PROCESSING
    } link_state_t;

    link_state_t state_reg, state_mid, state_next;
    logic        cts_reg, cts_next;
    logic        reading_reg, reading_mid, reading_next;
    logic [ctsg_pkg::BYTE_W-1:0] rcount_reg, rcount_mid, rcount_next;
    logic [ctsg_pkg::BYTE_W-1:0] req_byte_reg, reply_len_reg;
    logic unexpected, drop, reply_done, send;

    always_comb
    begin
        state_mid  = state_reg;
        cts_next   = cts_reg;
        rcount_mid = rcount_reg;
        unexpected = 1'b0;
        drop       = 1'b0;
        case (cmd)
            ctsg_pkg::CMD_PUT:
            begin
                drop = qstat.full;
            end
            ctsg_pkg::CMD_TX_EMPTY:
            begin
                case (state_reg)
                    ST_WAITING:   state_mid = ST_SLOW_BOX;
                    ST_BOTH_SLOW: state_mid = ST_PROCESSING;
                    default:      unexpected = 1'b1;
                endcase
            end
            ctsg_pkg::CMD_CTS_EDGE:
            begin
                cts_next = !cts_reg;
                if (cts_reg)
                begin
                    // line falls
                    case (state_reg)
                        ST_WAITING:  state_mid = ST_BOTH_SLOW;
                        ST_SLOW_BOX: state_mid = ST_PROCESSING;
                        default:     unexpected = 1'b1;
                    endcase
                end
                else
                begin
                    case (state_reg)
                        ST_PROCESSING: state_mid = ST_READY;
                        default:       unexpected = 1'b1;
                    endcase
                end
            end
            ctsg_pkg::CMD_RX_BYTE:
            begin
                rcount_mid = rcount_reg + 1'b1;
            end
            default:
            begin
                unexpected = 1'b0;
            end
        endcase

        reply_done  = (rcount_mid == reply_len_reg);
        rcount_next = reply_done ? '0 : rcount_mid;
        reading_mid = reading_reg && !reply_done;

        send         = (state_mid == ST_READY) && qstat.avail && !reading_mid;
        state_next   = send ? ST_WAITING : state_mid;
        reading_next = send ? (qstat.head == req_byte_reg) : reading_mid;
    end

    assign pop = step && send;

    always_comb
    begin
        res.tx_valid    = send;
        res.tx_byte     = send ? qstat.head : '0;
        res.status      = drop ? ctsg_pkg::STATUS_FULL
                        : (unexpected ? ctsg_pkg::STATUS_UNEXPECTED : ctsg_pkg::STATUS_OK);
        res.link_state  = state_next;
        res.sensor_busy = reading_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            cts_reg       <= 1'b1;
            reading_reg   <= 1'b0;
            rcount_reg    <= '0;
            req_byte_reg  <= ctsg_pkg::REQ_BYTE_RST;
            reply_len_reg <= ctsg_pkg::REPLY_LEN_RST;
        end
        else
        begin
            if (step)
            begin
                state_reg   <= state_next;
                cts_reg     <= cts_next;
                reading_reg <= reading_next;
                rcount_reg  <= rcount_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ctsg_pkg::CFG_REQ_BYTE:  req_byte_reg  <= cfg_data;
                    ctsg_pkg::CFG_REPLY_LEN: reply_len_reg <= cfg_data;
                    default:                 req_byte_reg  <= req_byte_reg;
                endcase
            end
        end
    end

endmodule

[hw/rtl/cts_paced_uart_tx_gate.sv]
// channel   dir  tdata / data                 tuser
// s_        in   [7:0] data_byte              [1:0] command
// m_        out  see m_tdata port comment     -
// cfg_      in   cfg_index, cfg_data          -
//
// one event per cycle sustained while m_ does not stall
// the event is decoded from an input register and the result lands in an output register
// a stalled m_ side holds both registers; s_tready falls only when both are full
// reset clears queue pointers, handshake state, counters, valid flags and config registers to defaults
// queue storage is not cleared and needs no sweep after reset
module cts_paced_uart_tx_gate #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ctsg_pkg::BYTE_W-1:0]        s_tdata,  // data_byte
    input  logic [ctsg_pkg::CMD_W-1:0]         s_tuser,  // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tx_valid, tx_byte[8:1], status[10:9], link_state[13:11], sensor_busy[14], zero
    output logic [ctsg_pkg::OUT_W-1:0]         m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ctsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctsg_pkg::BYTE_W-1:0]        cfg_data
);

    logic                          in_valid_reg;
    logic [ctsg_pkg::CMD_W-1:0]    in_cmd_reg;
    logic [ctsg_pkg::BYTE_W-1:0]   in_data_reg;
    logic                          out_valid_reg;
    logic [ctsg_pkg::OUT_W-1:0]    out_data_reg, out_data_next;
    logic advance, step, in_xfer;

    ctsg_pkg::q_ctrl_t qctrl;
    ctsg_pkg::q_stat_t qstat;
    ctsg_pkg::result_t res;
    logic              pop;

    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign qctrl.push = step && (in_cmd_reg == ctsg_pkg::CMD_PUT);
    assign qctrl.pop  = pop;
    assign qctrl.data = in_data_reg;

    ctsg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (qctrl),
        .stat  (qstat)
    );

    ctsg_link u_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .cmd       (in_cmd_reg),
        .qstat     (qstat),
        .pop       (pop),
        .res       (res)
    );

    assign out_data_next = {1'b0, res.sensor_busy, res.link_state, res.status,
                            res.tx_byte, res.tx_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hw/rtl/ctsg_check.sv]
module ctsg_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ctsg_pkg::OUT_W-1:0]      m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // with the result side drained the input side must be open
    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // no byte sent means the byte field is zero
    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[ctsg_pkg::OUT_TXV]
        |-> m_tdata[ctsg_pkg::OUT_STAT_L-1:ctsg_pkg::OUT_BYTE_L] == '0)
        else $error("tx_byte nonzero without tx_valid");

    // a sent byte always leaves the link in the waiting state
    a_send_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[ctsg_pkg::OUT_TXV]
        |-> m_tdata[ctsg_pkg::OUT_BUSY-1:ctsg_pkg::OUT_LINK_L] == ctsg_pkg::LS_WAITING)
        else $error("send without move to waiting");

endmodule

bind cts_paced_uart_tx_gate ctsg_check u_ctsg_check (.*);

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctsg_pkg::*;

    localparam int QDEPTH     = 64;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_PRINTS = 50;

    typedef enum logic [1:0] {TX_DROP, TX_RISE, CTS_FALL, CTS_RISE} link_move_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;   // data_byte
    logic [CMD_W-1:0]   s_tuser;   // command
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // tx_valid, tx_byte[8:1], status[10:9], link_state[13:11], sensor_busy[14], zero
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]  cfg_data;

    // predicted gate state
    logic [LINK_W-1:0]  link_st;
    bit                 cts_hi;
    logic [BYTE_W-1:0]  fifo_mem [QDEPTH];
    int unsigned        fifo_rd;
    int unsigned        fifo_fill;
    bit                 read_pending;
    logic [BYTE_W-1:0]  rx_cnt;
    logic [BYTE_W-1:0]  req_byte_cfg;
    logic [BYTE_W-1:0]  reply_len_cfg;

    result_t            step_results_q [$];
    int                 errors = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;

    cts_paced_uart_tx_gate #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic bit advance_link(link_move_t mv);
        logic [LINK_W-1:0] nxt;
        nxt = link_st;
        case (link_st)
            LS_READY:      if (mv == TX_DROP) nxt = LS_WAITING;
            LS_WAITING:
            begin
                if (mv == CTS_FALL)
                    nxt = LS_BOTH_SLOW;
                else if (mv == TX_RISE)
                    nxt = LS_SLOW_BOX;
            end
            LS_SLOW_BOX:   if (mv == CTS_FALL) nxt = LS_PROCESSING;
            LS_BOTH_SLOW:  if (mv == TX_RISE) nxt = LS_PROCESSING;
            LS_PROCESSING: if (mv == CTS_RISE) nxt = LS_READY;
            default:       nxt = link_st;
        endcase
        advance_link = (nxt != link_st);
        link_st = nxt;
    endfunction

    function automatic result_t gate_event(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
        result_t    r;
        link_move_t mv;
        logic [BYTE_W-1:0] b;
        r = '0;
        r.status = STATUS_OK;
        case (cmd)
            CMD_PUT:
            begin
                if (fifo_fill >= QDEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    fifo_mem[QAW'((fifo_rd + fifo_fill) % QDEPTH)] = data;
                    fifo_fill++;
                end
            end
            CMD_TX_EMPTY:
            begin
                if (!advance_link(TX_RISE))
                    r.status = STATUS_UNEXPECTED;
            end
            CMD_CTS_EDGE:
            begin
                // the level follows the wire even when the edge is unexpected
                mv = cts_hi ? CTS_FALL : CTS_RISE;
                cts_hi = !cts_hi;
                if (!advance_link(mv))
                    r.status = STATUS_UNEXPECTED;
            end
            default:
                rx_cnt = rx_cnt + 8'd1;
        endcase
        if (rx_cnt == reply_len_cfg)
        begin
            rx_cnt = '0;
            read_pending = 1'b0;
        end
        if (link_st == LS_READY && fifo_fill != 0 && !read_pending)
        begin
            b = fifo_mem[QAW'(fifo_rd)];
            fifo_rd = (fifo_rd + 1) % QDEPTH;
            fifo_fill--;
            if (b == req_byte_cfg)
                read_pending = 1'b1;
            void'(advance_link(TX_DROP));
            r.tx_valid = 1'b1;
            r.tx_byte = b;
        end
        r.link_state = link_st;
        r.sensor_busy = read_pending;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (errors < MAX_PRINTS)
            $display("tb: %s mismatch at %0t: got %0h, expected %0h", what, $realtime, got, exp_val);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.tx_valid    = m_tdata[OUT_TXV];
            got.tx_byte     = m_tdata[OUT_BYTE_L +: BYTE_W];
            got.status      = m_tdata[OUT_STAT_L +: STATUS_W];
            got.link_state  = m_tdata[OUT_LINK_L +: LINK_W];
            got.sensor_busy = m_tdata[OUT_BUSY];
            if (step_results_q.size() == 0)
                report_mismatch("unexpected result", int'(m_tdata), 0);
            else
            begin
                exp_r = step_results_q.pop_front();
                if (got.tx_valid !== exp_r.tx_valid)
                    report_mismatch("tx_valid", int'(got.tx_valid), int'(exp_r.tx_valid));
                if (got.tx_byte !== exp_r.tx_byte)
                    report_mismatch("tx_byte", int'(got.tx_byte), int'(exp_r.tx_byte));
                if (got.status !== exp_r.status)
                    report_mismatch("status", int'(got.status), int'(exp_r.status));
                if (got.link_state !== exp_r.link_state)
                    report_mismatch("link_state", int'(got.link_state),
                                    int'(exp_r.link_state));
                if (got.sensor_busy !== exp_r.sensor_busy)
                    report_mismatch("sensor_busy", int'(got.sensor_busy),
                                    int'(exp_r.sensor_busy));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // valid stays high into the next call, so a back-to-back transfer needs no toggle
    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        step_results_q.push_back(gate_event(cmd, data));
    endtask

    task automatic drain_to_idle();
        s_tvalid <= 1'b0;
        while (step_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [BYTE_W-1:0] req, input logic [BYTE_W-1:0] len);
        for (int i = 0; i < 2; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? CFG_REQ_BYTE : CFG_REPLY_LEN;
            cfg_data  <= (i == 0) ? req : len;
            do
                @(posedge clk);
            while (!cfg_ready);
            if (i == 0)
                req_byte_cfg = req;
            else
                reply_len_cfg = len;
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly legal handshake order with random content, plus some noise
    task automatic pick_event(output logic [CMD_W-1:0] cmd, output logic [BYTE_W-1:0] data);
        int r;
        data = 8'($urandom_range(255));
        if ($urandom_range(99) < 10)
            data = req_byte_cfg;
        r = $urandom_range(99);
        if ($urandom_range(99) < 25)
            cmd = 2'($urandom_range(3));
        else if (read_pending && r < 55)
            cmd = CMD_RX_BYTE;
        else if ((fifo_fill < 2 && r < 70) || r < 20)
            cmd = CMD_PUT;
        else
        begin
            case (link_st)
                LS_WAITING:    cmd = $urandom_range(1) ? CMD_TX_EMPTY : CMD_CTS_EDGE;
                LS_BOTH_SLOW:  cmd = CMD_TX_EMPTY;
                LS_SLOW_BOX:   cmd = CMD_CTS_EDGE;
                LS_PROCESSING: cmd = CMD_CTS_EDGE;
                default:       cmd = read_pending ? CMD_RX_BYTE : CMD_PUT;
            endcase
        end
    endtask

    task automatic run_traffic(input int n, input int idle, input int stall,
                               input logic [BYTE_W-1:0] req, input logic [BYTE_W-1:0] len);
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
        drain_to_idle();
        write_config(req, len);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n)
        begin
            if ($urandom_range(99) == 0)
                drain_to_idle();
            pick_event(cmd, data);
            send_event(cmd, data);
        end
    endtask

    // one full handshake cycle, unexpected events, a sensor read and its release
    task automatic test_handshake_cycle();
        idle_pct  = 0;
        stall_pct = 0;
        send_event(CMD_PUT, REQ_BYTE_RST);
        send_event(CMD_TX_EMPTY, 8'($urandom_range(255)));
        send_event(CMD_TX_EMPTY, 8'($urandom_range(255)));   // unexpected in slow box
        send_event(CMD_CTS_EDGE, 8'($urandom_range(255)));
        send_event(CMD_CTS_EDGE, 8'($urandom_range(255)));
        send_event(CMD_PUT, 8'hFF);
        send_event(CMD_PUT, 8'h00);
        repeat (REPLY_LEN_RST)
            send_event(CMD_RX_BYTE, 8'($urandom_range(255)));
        send_event(CMD_CTS_EDGE, 8'($urandom_range(255)));
        send_event(CMD_CTS_EDGE, 8'($urandom_range(255)));   // rise while both slow
        send_event(CMD_TX_EMPTY, 8'($urandom_range(255)));
        send_event(CMD_CTS_EDGE, 8'($urandom_range(255)));   // fall while processing
        send_event(CMD_CTS_EDGE, 8'($urandom_range(255)));
    endtask

    // link is waiting here, so puts pile up until the queue overflows
    task automatic test_fifo_overflow();
        repeat (QDEPTH + 2)
            send_event(CMD_PUT, 8'($urandom_range(255)));
    endtask

    task automatic test_no_idle();
        run_traffic(300, 0, 0, REQ_BYTE_RST, 8'd1);
    endtask

    task automatic test_sender_gaps();
        run_traffic(300, 68, 0, 8'h00, 8'd255);
    endtask

    task automatic test_reply_len_wrap();
        run_traffic(300, 0, 68, 8'hFF, 8'd0);
    endtask

    task automatic test_both_idle();
        run_traffic(400, 14, 14, 8'($urandom_range(255)), 8'($urandom_range(2, 12)));
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_PUT;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_REQ_BYTE;
        cfg_data  <= '0;
        req_byte_cfg  = REQ_BYTE_RST;
        reply_len_cfg = REPLY_LEN_RST;
        link_st       = LS_READY;
        cts_hi        = 1'b1;
        fifo_rd       = 0;
        fifo_fill     = 0;
        read_pending  = 1'b0;
        rx_cnt        = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_handshake_cycle();
        test_fifo_overflow();
        test_no_idle();
        test_sender_gaps();
        test_reply_len_wrap();
        test_both_idle();

        drain_to_idle();
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
